/* hdl/sq_pkg.sv */
// ----------------------------------------------------------------------------
// sq_pkg
// Shared constants and types for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sq_pkg;

  // queue geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // value returned by a pop on an empty queue
  localparam logic signed [DATA_W-1:0] EMPTY_POP_VALUE = -32'sd5;

  // command broadcast along the cell row
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage : sq_pkg

`default_nettype wire

/* hdl/sq_req_if.sv */
// ----------------------------------------------------------------------------
// sq_req_if
// Request channel: push or pop command with its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface sq_req_if import sq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface : sq_req_if

`default_nettype wire

/* hdl/sq_rsp_if.sv */
// ----------------------------------------------------------------------------
// sq_rsp_if
// Response channel: popped value, status and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface sq_rsp_if import sq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface : sq_rsp_if

`default_nettype wire

/* hdl/sorted_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded minimum priority queue held as a sorted row of compare-and-shift
// cells; the smallest entry sits in the first cell.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                              handshake
//  req      in   action, value                        valid / ready
//  rsp      out  popped_value, status, occupancy      valid / ready
//
//  One transaction per cycle: every cell compares and shifts in the same
//  cycle, so a request is done as it is taken and its response is registered.
//  A request is taken whenever the response register is empty or being taken.
//  Reset clears the fill count and the response valid; no clearing pass.
//  A stalled response holds the request side until it is taken.
//
`default_nettype none

module sorted_min_priority_queue import sq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sq_req_if.sink    req,
  sq_rsp_if.source  rsp
);

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  cmd_t                     cmd;
  logic                     rsp_valid;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic                     cell_lt   [DEPTH];

  // handshake and command decode
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign cmd.push  = accept && (req.action == ACT_PUSH) && !full;
  assign cmd.pop   = accept && (req.action == ACT_POP) && !empty;
  assign cmd.value = req.value;

  // row of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                     up_lt;
    logic signed [DATA_W-1:0] up_data;
    logic signed [DATA_W-1:0] down_data;

    if (k == 0) begin : g_first
      assign up_lt   = 1'b0;
      assign up_data = req.value;
    end else begin : g_mid
      assign up_lt   = cell_lt[k-1];
      assign up_data = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign down_data = cell_data[k];
    end else begin : g_inner
      assign down_data = cell_data[k+1];
    end

    sq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .head      (1'(k == 0)),
      .live      (CNT_W'(k) < count),
      .up_lt     (up_lt),
      .up_data   (up_data),
      .down_data (down_data),
      .lt        (cell_lt[k]),
      .data      (cell_data[k])
    );
  end

  // fill count
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= OCC_W'(count_next);
      if (req.action == ACT_PUSH) begin
        popped_value <= '0;
        status       <= full ? ST_FULL : ST_OK;
      end else if (empty) begin
        popped_value <= EMPTY_POP_VALUE;
        status       <= ST_EMPTY;
      end else begin
        popped_value <= cell_data[0];
        status       <= ST_OK;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.popped_value = popped_value;
  assign rsp.status       = status;
  assign rsp.occupancy    = occupancy;

endmodule : sorted_min_priority_queue

`default_nettype wire

/* hdl/sq_cell.sv */
// ----------------------------------------------------------------------------
// sq_cell
// One slot of the sorted row. Compares the pushed value with its entry and
// either keeps it, takes the new value or takes its upper neighbour's entry;
// on a pop it takes its lower neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sq_cell import sq_pkg::*; (
  input  wire logic                     clk,
  input  wire cmd_t                     cmd,
  input  wire logic                     head,       // first slot of the row
  input  wire logic                     live,       // slot holds a queued entry
  input  wire logic                     up_lt,      // upper neighbour stays put
  input  wire logic signed [DATA_W-1:0] up_data,
  input  wire logic signed [DATA_W-1:0] down_data,
  output logic                          lt,
  output logic signed [DATA_W-1:0]      data
);

  // entry is strictly smaller than the pushed value, so it keeps its place
  assign lt = live && (data < cmd.value);

  // shift down on push, shift up on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (!lt) begin
        data <= (head || up_lt) ? cmd.value : up_data;
      end
    end else if (cmd.pop) begin
      data <= down_data;
    end
  end

endmodule : sq_cell

`default_nettype wire

/* hdl/sq_checker.sv */
// ----------------------------------------------------------------------------
// sq_checker
// Port-level checks for the sorted minimum priority queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sq_checker import sq_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_valid,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire logic signed [DATA_W-1:0] popped_value,
  input wire logic [STAT_W-1:0]        status,
  input wire logic [OCC_W-1:0]         occupancy
);

  // empty pop reports the fixed value and an empty queue
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (popped_value == EMPTY_POP_VALUE &&
                                           occupancy == '0))
    else $error("empty pop response malformed");

  // dropped push only when the queue is at capacity
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (popped_value == '0 &&
                                          occupancy == OCC_W'(DEPTH)))
    else $error("full push response malformed");

  // occupancy never passes the capacity
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy above capacity");

  // a taken response with no new request leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && !(req_valid && req_ready)) |=> !rsp_valid)
    else $error("response repeated");

  // a request taken always produces a response next cycle
  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("response missing");

endmodule : sq_checker

bind sorted_min_priority_queue sq_checker u_sq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .popped_value (rsp.popped_value),
  .status       (rsp.status),
  .occupancy    (rsp.occupancy)
);

`default_nettype wire
